FILE: sv/ptrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptrm_pkg;

    localparam int PAGE_W     = 20;
    localparam int COUNT_W    = 12;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;

    localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
    localparam logic [OP_W-1:0] OP_UNMAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_VIRT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_PHYS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SRAM_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRAM_SIZE = 2'd1;

    localparam logic [COUNT_W-1:0] SRAM_SIZE_RESET = 12'd2048;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  virt_page;
        logic [PAGE_W-1:0]  phys_page;
        logic [COUNT_W-1:0] page_count;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   result_page;
        logic                entry_enabled;
    } res_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  sram_base_page;
        logic [COUNT_W-1:0] sram_size_pages;
    } cfg_t;

endpackage
`default_nettype wire

FILE: sv/ptrm_table.sv
`timescale 1ns / 1ps
`default_nettype none
module ptrm_table #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/ptrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ptrm_ctrl
    import ptrm_pkg::*;
#(
    parameter int PAGE_BITS   = 11,
    parameter int TABLE_DEPTH = 2048
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  item_valid,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  out_free,
    output logic       idle,
    output logic       done,
    output res_t       res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int ENT_W = PAGE_BITS + 1;
    localparam logic [PAGE_W:0]    DEPTH_EXT = (PAGE_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_LOOK,
        S_DONE
    } state_t;

    state_t               state_reg;
    item_t                item_reg;
    res_t                 res_reg;
    logic [IDX_W-1:0]     clr_addr_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [COUNT_W-1:0]   remain_reg;
    logic                 wb_valid_reg;
    logic [IDX_W-1:0]     wb_addr_reg;

    logic [PAGE_W-1:0]    idx_full;
    logic                 below;
    logic [PAGE_W:0]      run_end;
    logic [PAGE_W:0]      phys_end;
    logic [PAGE_W:0]      sram_end;
    logic                 virt_run_bad;
    logic                 virt_look_bad;
    logic                 phys_bad;
    logic [STATUS_W-1:0]  chk_status;
    logic                 is_map;
    logic                 is_unmap;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENT_W-1:0]     rd_data;

    // Range checks on the registered item, in the cycle after the transaction.
    always_comb begin
        idx_full      = item_reg.virt_page - cfg.sram_base_page;
        below         = item_reg.virt_page < cfg.sram_base_page;
        run_end       = {1'b0, idx_full} + (PAGE_W + 1)'(item_reg.page_count);
        phys_end      = {1'b0, item_reg.phys_page} + (PAGE_W + 1)'(item_reg.page_count);
        sram_end      = {1'b0, cfg.sram_base_page} + (PAGE_W + 1)'(cfg.sram_size_pages);
        virt_run_bad  = below || (run_end > DEPTH_EXT);
        virt_look_bad = below || ({1'b0, idx_full} >= DEPTH_EXT);
        phys_bad      = (item_reg.phys_page < cfg.sram_base_page) || (phys_end > sram_end);
        is_map        = item_reg.op == OP_MAP;
        is_unmap      = item_reg.op == OP_UNMAP;

        unique case (item_reg.op)
            OP_MAP: begin
                if (virt_run_bad) begin
                    chk_status = STAT_VIRT_RANGE;
                end else if (phys_bad) begin
                    chk_status = STAT_PHYS_RANGE;
                end else begin
                    chk_status = STAT_OK;
                end
            end
            OP_UNMAP: begin
                chk_status = virt_run_bad ? STAT_VIRT_RANGE : STAT_OK;
            end
            OP_LOOKUP: begin
                chk_status = virt_look_bad ? STAT_VIRT_RANGE : STAT_OK;
            end
            default: begin
                chk_status = STAT_OK;
            end
        endcase
    end

    // Unmap is a read-modify-write: the entry read in one cycle is written back
    // with its enable bit cleared in the next, while the following entry is read.
    always_comb begin
        wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_RUN) && is_map) || wb_valid_reg;
        wr_addr = wb_addr_reg;
        wr_data = {1'b0, rd_data[PAGE_BITS-1:0]};
        priority if (state_reg == S_CLEAR) begin
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else if ((state_reg == S_RUN) && is_map) begin
            wr_addr = idx_reg;
            wr_data = {1'b1, page_reg};
        end else begin
            wr_addr = wb_addr_reg;
            wr_data = {1'b0, rd_data[PAGE_BITS-1:0]};
        end

        rd_en   = ((state_reg == S_CHECK) && (item_reg.op == OP_LOOKUP))
                  || ((state_reg == S_RUN) && is_unmap);
        rd_addr = (state_reg == S_CHECK) ? idx_full[IDX_W-1:0] : idx_reg;
    end

    ptrm_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            wb_valid_reg <= (state_reg == S_RUN) && is_unmap;
            wb_addr_reg  <= idx_reg;

            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_IDX) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (item_valid) begin
                        item_reg  <= item;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    res_reg.status        <= chk_status;
                    res_reg.result_page   <= '0;
                    res_reg.entry_enabled <= 1'b0;
                    idx_reg               <= idx_full[IDX_W-1:0];
                    page_reg              <= item_reg.phys_page[PAGE_BITS-1:0];
                    remain_reg            <= item_reg.page_count;
                    if (chk_status != STAT_OK) begin
                        state_reg <= S_DONE;
                    end else if (is_map || is_unmap) begin
                        state_reg <= (item_reg.page_count == '0) ? S_DONE : S_RUN;
                    end else if (item_reg.op == OP_LOOKUP) begin
                        state_reg <= S_LOOK;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_RUN: begin
                    idx_reg    <= idx_reg + 1'b1;
                    page_reg   <= page_reg + 1'b1;
                    remain_reg <= remain_reg - 1'b1;
                    if (remain_reg == COUNT_W'(1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_LOOK: begin
                    res_reg.result_page   <= PAGE_W'(rd_data[PAGE_BITS-1:0])
                                             + cfg.sram_base_page;
                    res_reg.entry_enabled <= rd_data[PAGE_BITS];
                    state_reg             <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle = state_reg == S_IDLE;
    assign done = state_reg == S_DONE;
    assign res  = res_reg;

endmodule
`default_nettype wire

FILE: sv/page_tlb_range_mapper.sv
// Channel   Direction  Handshake          Contents
// s_        in         s_tvalid/s_tready  one map, unmap or lookup request
// m_        out        m_tvalid/m_tready  one status and lookup result per request
// cfg_      in         cfg_valid/cfg_ready register writes (always ready)
//
// A request that is refused, has an empty run or is an unknown op goes from its range check
// straight to its result; a lookup first reads its table entry, and a map or unmap walks
// its page_count entries: the single write port of the table stores one entry per cycle.
// A new request is taken once the previous result sits in the output
// register. After reset a clearing pass writes all TABLE_DEPTH entries, one per
// cycle, before the first request is taken. A stalled m_ side holds the result.
`timescale 1ns / 1ps
`default_nettype none
module page_tlb_range_mapper
    import ptrm_pkg::*;
#(
    parameter int PAGE_BITS   = 11,
    parameter int TABLE_DEPTH = 2048
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // virt_page, phys_page, page_count
    input  wire logic [OP_W-1:0]       s_tuser,  // op

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,  // result_page, entry_enabled
    output logic      [STATUS_W-1:0]   m_tuser,  // status

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    item_t item;
    res_t  res;
    logic  ctrl_idle;
    logic  ctrl_done;
    logic  out_free;
    logic  m_tvalid_reg;
    res_t  m_res_reg;

    always_comb begin
        item.op         = s_tuser;
        item.virt_page  = s_tdata[PAGE_W-1:0];
        item.phys_page  = s_tdata[2*PAGE_W-1:PAGE_W];
        item.page_count = s_tdata[2*PAGE_W+COUNT_W-1:2*PAGE_W];
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sram_base_page  <= '0;
            cfg_reg.sram_size_pages <= SRAM_SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SRAM_BASE: begin
                    cfg_reg.sram_base_page <= cfg_data;
                end
                CFG_SRAM_SIZE: begin
                    cfg_reg.sram_size_pages <= cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    ptrm_ctrl #(
        .PAGE_BITS   (PAGE_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid && ctrl_idle),
        .item       (item),
        .cfg        (cfg_reg),
        .out_free   (out_free),
        .idle       (ctrl_idle),
        .done       (ctrl_done),
        .res        (res)
    );

    assign s_tready = ctrl_idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl_done && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_res_reg    <= res;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - PAGE_W - 1){1'b0}},
                       m_res_reg.entry_enabled, m_res_reg.result_page};
    assign m_tuser  = m_res_reg.status;

endmodule
`default_nettype wire

FILE: tb/sv/ptrm_translation_checker.sv
`timescale 1ns / 1ps
module ptrm_translation_checker
    import ptrm_pkg::*;
#(
    parameter int PAGE_BITS   = 11,
    parameter int TABLE_DEPTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // virt_page, phys_page, page_count
    input  logic [OP_W-1:0]       s_tuser,   // op

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // result_page, entry_enabled
    input  logic [STATUS_W-1:0]   m_tuser,   // status

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatch_count,
    output int                    results_seen
);

    // Each entry holds the low physical page bits with the enable bit on top.
    logic [PAGE_BITS:0]  xlat_table [TABLE_DEPTH];
    logic [PAGE_W-1:0]   window_base;
    logic [COUNT_W-1:0]  window_pages;
    res_t                expected_results [$];

    initial begin
        mismatch_count = 0;
        results_seen   = 0;
    end

    // Applies one request to the shadow table and returns the result it should give.
    function automatic res_t translate_request(item_t rq);
        res_t   r;
        logic   below;
        longint idx;
        int     k;
        r     = '0;
        below = rq.virt_page < window_base;
        idx   = below ? 0 : longint'(rq.virt_page) - longint'(window_base);
        if (rq.op == OP_MAP || rq.op == OP_UNMAP) begin
            if (below || idx + longint'(rq.page_count) > TABLE_DEPTH) begin
                r.status = STAT_VIRT_RANGE;
            end else if (rq.op == OP_MAP && (rq.phys_page < window_base ||
                    longint'(rq.phys_page) + longint'(rq.page_count) >
                    longint'(window_base) + longint'(window_pages))) begin
                r.status = STAT_PHYS_RANGE;
            end else begin
                for (k = 0; k < int'(rq.page_count); k++) begin
                    if (rq.op == OP_MAP)
                        xlat_table[int'(idx) + k] =
                            {1'b1, PAGE_BITS'(rq.phys_page + PAGE_W'(k))};
                    else
                        xlat_table[int'(idx) + k][PAGE_BITS] = 1'b0;
                end
            end
        end else if (rq.op == OP_LOOKUP) begin
            if (below || idx >= TABLE_DEPTH) begin
                r.status = STAT_VIRT_RANGE;
            end else begin
                // The enable bit does not gate the translation, and the sum wraps.
                r.result_page   = PAGE_W'(xlat_table[int'(idx)][PAGE_BITS-1:0]) + window_base;
                r.entry_enabled = xlat_table[int'(idx)][PAGE_BITS];
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t  seen;
        res_t  want;
        item_t rq;
        int    errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                xlat_table[i] = '0;
            window_base  = '0;
            window_pages = SRAM_SIZE_RESET;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SRAM_BASE)
                    window_base = cfg_data;
                else if (cfg_index == CFG_SRAM_SIZE)
                    window_pages = cfg_data[COUNT_W-1:0];
            end

            if (m_tvalid && m_tready) begin
                seen.status        = m_tuser;
                seen.result_page   = m_tdata[PAGE_W-1:0];
                seen.entry_enabled = m_tdata[PAGE_W];
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d, result_page 0x%05h, entry_enabled %0d",
                           seen.status, seen.result_page, seen.entry_enabled);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        errs++;
                    end
                    if (seen.result_page !== want.result_page) begin
                        $error("result_page: expected 0x%05h, got 0x%05h",
                               want.result_page, seen.result_page);
                        errs++;
                    end
                    if (seen.entry_enabled !== want.entry_enabled) begin
                        $error("entry_enabled: expected %0d, got %0d",
                               want.entry_enabled, seen.entry_enabled);
                        errs++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                rq.op         = s_tuser;
                rq.virt_page  = s_tdata[PAGE_W-1:0];
                rq.phys_page  = s_tdata[2*PAGE_W-1:PAGE_W];
                rq.page_count = s_tdata[2*PAGE_W+COUNT_W-1:2*PAGE_W];
                expected_results.push_back(translate_request(rq));
            end

            if (errs != 0)
                mismatch_count <= mismatch_count + errs;
        end
    end

endmodule

FILE: tb/sv/page_tlb_range_mapper_tb.sv
`timescale 1ns / 1ps
module page_tlb_range_mapper_tb;
    import ptrm_pkg::*;

    localparam int TABLE_DEPTH     = 2048;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 50;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int WINDOW_PHASES   = 8;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // virt_page, phys_page, page_count
    logic [OP_W-1:0]       s_tuser   = '0;   // op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // result_page, entry_enabled
    logic [STATUS_W-1:0]   m_tuser;          // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   mismatch_count;
    int   results_seen;
    int   requests_sent = 0;
    int   op_tally [4];
    int   windows_used  = 1;
    int   quiet_cycles  = 0;
    bit   steady_flow   = 1'b0;
    cfg_t window        = '{sram_base_page: '0, sram_size_pages: SRAM_SIZE_RESET};

    always #5 aclk = ~aclk;

    page_tlb_range_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptrm_translation_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_seen   (results_seen)
    );

    function automatic item_t request_of(logic [OP_W-1:0] op, logic [PAGE_W-1:0] vp,
                                         logic [PAGE_W-1:0] pp, logic [COUNT_W-1:0] cnt);
        item_t rq;
        rq.op         = op;
        rq.virt_page  = vp;
        rq.phys_page  = pp;
        rq.page_count = cnt;
        return rq;
    endfunction

    // Mostly legal runs inside the current window, then edge cases and pure noise.
    function automatic item_t make_request();
        item_t rq;
        int    pick;
        int    op_pick;
        int    idx;
        int    span;
        pick          = $urandom_range(0, 99);
        rq.op         = OP_LOOKUP;
        rq.phys_page  = PAGE_W'($urandom);
        rq.page_count = '0;
        if (pick < 75) begin
            if ($urandom_range(0, 39) == 0)
                rq.page_count = COUNT_W'($urandom_range(256, TABLE_DEPTH));
            else
                rq.page_count = COUNT_W'($urandom_range(0, 24));
            // Most traffic lands in a small region so that lookups hit mapped entries.
            idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 255)
                                             : $urandom_range(0, TABLE_DEPTH - 1);
            op_pick = $urandom_range(0, 9);
            rq.op = (op_pick < 4) ? OP_MAP : (op_pick < 6) ? OP_UNMAP : OP_LOOKUP;
            if (rq.op != OP_LOOKUP && idx + rq.page_count > TABLE_DEPTH)
                idx = TABLE_DEPTH - rq.page_count;
            rq.virt_page = PAGE_W'(window.sram_base_page + idx);
            span = int'(window.sram_size_pages) - int'(rq.page_count);
            if (rq.op == OP_MAP && span >= 0)
                rq.phys_page = PAGE_W'(window.sram_base_page + $urandom_range(0, span));
        end else if (pick < 88) begin
            rq.op         = OP_W'($urandom_range(0, 2));
            rq.page_count = COUNT_W'($urandom_range(0, 32));
            rq.virt_page  = window.sram_base_page;
            rq.phys_page  = window.sram_base_page;
            case ($urandom_range(0, 3))
                0: rq.virt_page = PAGE_W'(window.sram_base_page + TABLE_DEPTH
                                          - rq.page_count + $urandom_range(0, 2));
                1: rq.phys_page = PAGE_W'(window.sram_base_page + window.sram_size_pages
                                          - rq.page_count + $urandom_range(0, 2));
                2: rq.virt_page = PAGE_W'(window.sram_base_page - $urandom_range(1, 3));
                default: rq.phys_page = PAGE_W'(window.sram_base_page - $urandom_range(1, 3));
            endcase
        end else begin
            rq.op         = OP_W'($urandom_range(0, 3));
            rq.virt_page  = PAGE_W'($urandom);
            rq.phys_page  = PAGE_W'($urandom);
            rq.page_count = COUNT_W'($urandom_range(0, TABLE_DEPTH));
        end
        return rq;
    endfunction

    // s_tvalid stays high across back-to-back transactions; this task lowers it only for a gap.
    task automatic send_request(input item_t rq);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({rq.page_count, rq.phys_page, rq.virt_page});
        s_tuser  <= rq.op;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        op_tally[rq.op]++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_seen < requests_sent);
    endtask

    task automatic set_window(input cfg_t w);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SRAM_BASE;
        cfg_data  <= w.sram_base_page;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_SRAM_SIZE;
        cfg_data  <= CFG_DATA_W'(w.sram_size_pages);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window = w;
        windows_used++;
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[page_tlb_range_mapper] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        cfg_t windows [WINDOW_PHASES];
        int   phase;
        int   n;
        windows[0] = '{sram_base_page: 20'h00000, sram_size_pages: 12'd2048};
        windows[1] = '{sram_base_page: 20'h00400, sram_size_pages: 12'd512};
        windows[2] = '{sram_base_page: 20'hFFA00, sram_size_pages: 12'd2048};
        windows[3] = '{sram_base_page: 20'h00000, sram_size_pages: 12'd0};
        for (phase = 4; phase < WINDOW_PHASES; phase++) begin
            windows[phase].sram_base_page  = $urandom_range(0, 1) ? PAGE_W'($urandom_range(0, 4096))
                                                                  : PAGE_W'($urandom);
            windows[phase].sram_size_pages = COUNT_W'($urandom_range(0, TABLE_DEPTH));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window: a cleared table, a full-table map and the range checks at the edges.
        send_request(request_of(OP_LOOKUP, 20'd0,     20'd0,     12'd0));
        send_request(request_of(OP_MAP,    20'd0,     20'd0,     12'd2048));
        send_request(request_of(OP_LOOKUP, 20'd2047,  20'hFFFFF, 12'd2048));
        send_request(request_of(OP_UNMAP,  20'd100,   20'd0,     12'd16));
        send_request(request_of(OP_LOOKUP, 20'd100,   20'd0,     12'd0));
        send_request(request_of(OP_MAP,    20'd2047,  20'd2047,  12'd1));
        send_request(request_of(OP_MAP,    20'd2047,  20'd0,     12'd2));
        send_request(request_of(OP_UNMAP,  20'd2040,  20'd0,     12'd9));
        send_request(request_of(OP_LOOKUP, 20'd2048,  20'd0,     12'd0));
        send_request(request_of(OP_LOOKUP, 20'hFFFFF, 20'd0,     12'd0));
        send_request(request_of(OP_MAP,    20'd10,    20'd2047,  12'd2));
        send_request(request_of(OP_MAP,    20'd10,    20'hFFFFF, 12'd0));
        send_request(request_of(OP_MAP,    20'd3000,  20'hFFFFF, 12'd0));
        send_request(request_of(OP_MAP,    20'd5,     20'd0,     12'd0));
        send_request(request_of(OP_UNMAP,  20'd0,     20'd0,     12'd0));
        send_request(request_of(OP_UNUSED, 20'hFFFFF, 20'hFFFFF, 12'd2048));
        send_request(request_of(OP_MAP,    20'd0,     20'd2040,  12'd8));
        send_request(request_of(OP_LOOKUP, 20'd5,     20'd0,     12'd0));

        // Pages below the window base, and the last page of a small SRAM.
        drain_results();
        set_window('{sram_base_page: 20'h00400, sram_size_pages: 12'd16});
        send_request(request_of(OP_MAP,    20'h003FF, 20'h00400, 12'd1));
        send_request(request_of(OP_MAP,    20'h00400, 20'h003FF, 12'd1));
        send_request(request_of(OP_MAP,    20'h00400, 20'h0040F, 12'd1));
        send_request(request_of(OP_LOOKUP, 20'h00400, 20'd0,     12'd0));

        // With the base at the top page the translated page wraps round.
        drain_results();
        set_window('{sram_base_page: 20'hFFFFF, sram_size_pages: 12'd2048});
        send_request(request_of(OP_MAP,    20'hFFFFF, 20'hFFFFF, 12'd1));
        send_request(request_of(OP_LOOKUP, 20'hFFFFF, 20'd0,     12'd0));

        for (phase = 0; phase < WINDOW_PHASES; phase++) begin
            drain_results();
            set_window(windows[phase]);
            for (n = 0; n < RANDOM_REQUESTS / WINDOW_PHASES; n++) begin
                if (n % 50 == 0)
                    steady_flow = ($urandom_range(0, 3) == 0);
                send_request(make_request());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d map, %0d unmap, %0d lookup, %0d unused op) over %0d windows.",
                 requests_sent, op_tally[OP_MAP], op_tally[OP_UNMAP], op_tally[OP_LOOKUP],
                 op_tally[OP_UNUSED], windows_used);
        $display("%0d results compared, %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("[page_tlb_range_mapper] OK");
        else
            $display("[page_tlb_range_mapper] ERROR");
        $finish;
    end

endmodule
